// File: rtl/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types, constants and opcodes of the accumulator processor.
// ----------------------------------------------------------------------------
package acpu_pkg;

  localparam int unsigned MemWordsDefault = 2048;
  localparam int unsigned PeriodReset     = 100;
  localparam int unsigned UserLimit       = 1000;
  localparam int unsigned SysStackTop     = 2000;
  localparam int unsigned TimerVector     = 1000;
  localparam int unsigned SyscallVector   = 1500;
  localparam int unsigned SpReset         = 1000;

  // opcodes
  localparam logic [31:0] OpLoadVal  = 32'd1;
  localparam logic [31:0] OpLoadAddr = 32'd2;
  localparam logic [31:0] OpLoadInd  = 32'd3;
  localparam logic [31:0] OpLoadX    = 32'd4;
  localparam logic [31:0] OpLoadY    = 32'd5;
  localparam logic [31:0] OpLoadSpX  = 32'd6;
  localparam logic [31:0] OpStore    = 32'd7;
  localparam logic [31:0] OpRand     = 32'd8;
  localparam logic [31:0] OpPut      = 32'd9;
  localparam logic [31:0] OpAddX     = 32'd10;
  localparam logic [31:0] OpAddY     = 32'd11;
  localparam logic [31:0] OpSubX     = 32'd12;
  localparam logic [31:0] OpSubY     = 32'd13;
  localparam logic [31:0] OpCopyToX  = 32'd14;
  localparam logic [31:0] OpCopyFrX  = 32'd15;
  localparam logic [31:0] OpCopyToY  = 32'd16;
  localparam logic [31:0] OpCopyFrY  = 32'd17;
  localparam logic [31:0] OpCopyToSp = 32'd18;
  localparam logic [31:0] OpCopyFrSp = 32'd19;
  localparam logic [31:0] OpJump     = 32'd20;
  localparam logic [31:0] OpJumpEq   = 32'd21;
  localparam logic [31:0] OpJumpNe   = 32'd22;
  localparam logic [31:0] OpCall     = 32'd23;
  localparam logic [31:0] OpRet      = 32'd24;
  localparam logic [31:0] OpIncX     = 32'd25;
  localparam logic [31:0] OpDecX     = 32'd26;
  localparam logic [31:0] OpPush     = 32'd27;
  localparam logic [31:0] OpPop      = 32'd28;
  localparam logic [31:0] OpSyscall  = 32'd29;
  localparam logic [31:0] OpIret     = 32'd30;
  localparam logic [31:0] OpEnd      = 32'd50;

  // status codes
  localparam logic [2:0] StNone   = 3'd0;
  localparam logic [2:0] StInt    = 3'd1;
  localparam logic [2:0] StChar   = 3'd2;
  localparam logic [2:0] StHalt   = 3'd3;
  localparam logic [2:0] StBadOp  = 3'd4;
  localparam logic [2:0] StAccess = 3'd5;

  // interrupt kinds
  localparam logic [1:0] IntNone  = 2'd0;
  localparam logic [1:0] IntSys   = 2'd1;
  localparam logic [1:0] IntTimer = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [10:0]        load_address;
    logic signed [31:0] load_data;
    logic [6:0]         random_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] print_value;
    logic [10:0]        program_counter;
    logic               kernel_mode;
  } out_word_t;

endpackage

// File: rtl/accumulator_cpu_with_interrupts.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_with_interrupts
// Accumulator processor with a word memory, timer interrupt and syscall.
// ----------------------------------------------------------------------------
// Each input word either writes one memory word (mode 0) or executes one
// instruction (mode 1). The whole state machine goes through a single-port
// memory with registered read data. A halted core answers an instruction word
// with a halt status and touches no memory. An instruction fetches its opcode,
// reads each further memory operand in turn and then builds the result; when a
// timer interrupt is taken first, the resume address and the saved stack pointer
// are written to the system stack before the fetch. One word is in work at a
// time; the result sits in an output register and the next input word is taken
// while it waits. Memory is not cleared after reset.
module accumulator_cpu_with_interrupts #(
  parameter int unsigned MemWords = acpu_pkg::MemWordsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  acpu_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output acpu_pkg::out_word_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_data_i
);

  localparam int unsigned AW = $clog2(MemWords);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SIrq1  = 4'd1;  // write resume address
  localparam logic [3:0] SIrq2  = 4'd2;  // write saved sp
  localparam logic [3:0] SFetch = 4'd3;  // opcode read issued
  localparam logic [3:0] SDec   = 4'd4;  // opcode available
  localparam logic [3:0] SRd1   = 4'd5;  // first operand available
  localparam logic [3:0] SRd2   = 4'd6;  // second operand available
  localparam logic [3:0] SRd3   = 4'd7;  // third operand available
  localparam logic [3:0] SSys2  = 4'd8;  // syscall second stack write
  localparam logic [3:0] SDone  = 4'd9;  // finish, build result
  localparam logic [3:0] SLoad  = 4'd10; // load mode write

  logic [3:0]  state_q, state_d;
  logic [31:0] pc_q, pc_d, next_q, next_d;
  logic [31:0] sp_q, sp_d, ac_q, ac_d, x_q, x_d, y_q, y_d;
  logic        kern_q, kern_d, tpend_q, tpend_d, halt_q, halt_d;
  logic [1:0]  ikind_q, ikind_d;
  logic [15:0] tick_q, tick_d, period_q;
  logic [31:0] op_q, op_d, tmp_q, tmp_d;
  logic        viol_q, viol_d, bad_q, bad_d, stop_q, stop_d;
  logic [2:0]  pst_q, pst_d;
  logic        ovalid_q, ovalid_d;
  acpu_pkg::out_word_t odata_q, odata_d;
  acpu_pkg::in_word_t  inw_q, inw_d;

  logic          we;
  logic [31:0]   maddr, wdata, rdata;
  logic          acc;
  logic [16:0]   period_ext;
  logic [16:0]   tick_inc;

  acpu_mem #(.MemWords(MemWords)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (maddr[AW-1:0]),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // timer period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 16'(acpu_pkg::PeriodReset);
    end else if (cfg_we_i) begin
      period_q <= cfg_data_i;
    end
  end

  assign period_ext = (period_q == 16'd0) ? 17'h10000 : {1'b0, period_q};
  assign tick_inc   = {1'b0, tick_q} + 17'd1;

  // sequencer: one memory access per cycle
  always_comb begin
    state_d = state_q; pc_d = pc_q; next_d = next_q; sp_d = sp_q;
    ac_d = ac_q; x_d = x_q; y_d = y_q; kern_d = kern_q; tpend_d = tpend_q;
    halt_d = halt_q; ikind_d = ikind_q; tick_d = tick_q; op_d = op_q;
    tmp_d = tmp_q; viol_d = viol_q; bad_d = bad_q; stop_d = stop_q;
    pst_d = pst_q; ovalid_d = ovalid_q; odata_d = odata_q; inw_d = inw_q;
    we = 1'b0; maddr = pc_q; wdata = ac_q; acc = 1'b0;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          inw_d = in_data_i;
          viol_d = 1'b0; bad_d = 1'b0; stop_d = 1'b0; pst_d = acpu_pkg::StNone;
          if (!in_data_i.mode) begin
            state_d = SLoad;
          end else if (halt_q) begin
            pst_d = acpu_pkg::StHalt;
            state_d = SDone;
          end else if (tpend_q && ikind_q == acpu_pkg::IntNone) begin
            tpend_d = 1'b0;
            ikind_d = acpu_pkg::IntTimer;
            kern_d  = 1'b1;
            state_d = SIrq1;
          end else begin
            maddr = pc_q; acc = 1'b1;
            state_d = SFetch;
          end
        end
      end
      SLoad: begin
        we = 1'b1;
        maddr = {21'd0, inw_q.load_address};
        wdata = inw_q.load_data;
        state_d = SDone;
      end
      SIrq1: begin
        we = 1'b1; maddr = 32'(acpu_pkg::SysStackTop - 1); wdata = pc_q;
        state_d = SIrq2;
      end
      SIrq2: begin
        we = 1'b1; maddr = 32'(acpu_pkg::SysStackTop - 2); wdata = sp_q;
        sp_d = 32'(acpu_pkg::SysStackTop - 2);
        pc_d = 32'(acpu_pkg::TimerVector);
        state_d = SFetch;
      end
      SFetch: begin
        maddr = pc_q; acc = 1'b1;
        state_d = SDec;
      end
      SDec: begin
        op_d = rdata;
        next_d = pc_q + 32'd1;
        state_d = SDone;
        unique case (rdata)
          acpu_pkg::OpLoadVal, acpu_pkg::OpLoadAddr, acpu_pkg::OpLoadInd,
          acpu_pkg::OpLoadX, acpu_pkg::OpLoadY, acpu_pkg::OpStore,
          acpu_pkg::OpPut, acpu_pkg::OpJump, acpu_pkg::OpJumpEq,
          acpu_pkg::OpJumpNe, acpu_pkg::OpCall: begin
            maddr = pc_q + 32'd1; acc = 1'b1;
            state_d = SRd1;
          end
          acpu_pkg::OpLoadSpX: begin
            maddr = sp_q + x_q; acc = 1'b1; state_d = SRd1;
          end
          acpu_pkg::OpRet, acpu_pkg::OpPop, acpu_pkg::OpIret: begin
            maddr = sp_q; acc = 1'b1; state_d = SRd1;
          end
          acpu_pkg::OpPush: begin
            sp_d = sp_q - 32'd1;
            maddr = sp_q - 32'd1; we = 1'b1; acc = 1'b1; wdata = ac_q;
          end
          acpu_pkg::OpRand: ac_d = {25'd0, inw_q.random_value};
          acpu_pkg::OpAddX: ac_d = ac_q + x_q;
          acpu_pkg::OpAddY: ac_d = ac_q + y_q;
          acpu_pkg::OpSubX: ac_d = ac_q - x_q;
          acpu_pkg::OpSubY: ac_d = ac_q - y_q;
          acpu_pkg::OpCopyToX: x_d = ac_q;
          acpu_pkg::OpCopyFrX: ac_d = x_q;
          acpu_pkg::OpCopyToY: y_d = ac_q;
          acpu_pkg::OpCopyFrY: ac_d = y_q;
          acpu_pkg::OpCopyToSp: sp_d = ac_q;
          acpu_pkg::OpCopyFrSp: ac_d = sp_q;
          acpu_pkg::OpIncX: x_d = x_q + 32'd1;
          acpu_pkg::OpDecX: x_d = x_q - 32'd1;
          acpu_pkg::OpSyscall: begin
            if (ikind_q == acpu_pkg::IntNone) begin
              ikind_d = acpu_pkg::IntSys;
              kern_d = 1'b1;
              we = 1'b1; maddr = 32'(acpu_pkg::SysStackTop - 1);
              wdata = pc_q + 32'd1;
              next_d = 32'(acpu_pkg::SyscallVector);
              state_d = SSys2;
            end
          end
          acpu_pkg::OpEnd: stop_d = 1'b1;
          default: bad_d = 1'b1;
        endcase
      end
      SSys2: begin
        we = 1'b1; maddr = 32'(acpu_pkg::SysStackTop - 2); wdata = sp_q;
        sp_d = 32'(acpu_pkg::SysStackTop - 2);
        state_d = SDone;
      end
      SRd1: begin
        tmp_d = rdata;
        state_d = SDone;
        unique case (op_q)
          acpu_pkg::OpLoadVal: begin ac_d = rdata; next_d = pc_q + 32'd2; end
          acpu_pkg::OpLoadAddr, acpu_pkg::OpLoadInd: begin
            maddr = rdata; acc = 1'b1; next_d = pc_q + 32'd2; state_d = SRd2;
          end
          acpu_pkg::OpLoadX: begin
            maddr = rdata + x_q; acc = 1'b1; next_d = pc_q + 32'd2; state_d = SRd2;
          end
          acpu_pkg::OpLoadY: begin
            maddr = rdata + y_q; acc = 1'b1; next_d = pc_q + 32'd2; state_d = SRd2;
          end
          acpu_pkg::OpLoadSpX, acpu_pkg::OpPop: begin
            ac_d = rdata;
            if (op_q == acpu_pkg::OpPop) sp_d = sp_q + 32'd1;
          end
          acpu_pkg::OpStore: begin
            maddr = rdata; we = 1'b1; acc = 1'b1; wdata = ac_q;
            next_d = pc_q + 32'd2;
          end
          acpu_pkg::OpPut: begin
            next_d = pc_q + 32'd2;
            if (rdata == 32'd1) pst_d = acpu_pkg::StInt;
            else if (rdata == 32'd2) pst_d = acpu_pkg::StChar;
          end
          acpu_pkg::OpJump: next_d = rdata;
          acpu_pkg::OpJumpEq: next_d = (ac_q == 32'd0) ? rdata : pc_q + 32'd2;
          acpu_pkg::OpJumpNe: next_d = (ac_q != 32'd0) ? rdata : pc_q + 32'd2;
          acpu_pkg::OpCall: begin
            sp_d = sp_q - 32'd1;
            maddr = sp_q - 32'd1; we = 1'b1; acc = 1'b1; wdata = pc_q + 32'd2;
            next_d = rdata;
          end
          acpu_pkg::OpRet: begin next_d = rdata; sp_d = sp_q + 32'd1; end
          acpu_pkg::OpIret: begin
            maddr = sp_q + 32'd1; acc = 1'b1; state_d = SRd2;
          end
          default: ;
        endcase
      end
      SRd2: begin
        state_d = SDone;
        unique case (op_q)
          acpu_pkg::OpLoadInd: begin maddr = rdata; acc = 1'b1; state_d = SRd3; end
          acpu_pkg::OpIret: begin
            next_d = rdata;
            if (ikind_q == acpu_pkg::IntTimer) tpend_d = 1'b0;
            ikind_d = acpu_pkg::IntNone;
            sp_d = tmp_q;
            kern_d = 1'b0;
          end
          default: ac_d = rdata;
        endcase
      end
      SRd3: begin
        ac_d = rdata;
        state_d = SDone;
      end
      SDone: begin
        if (!ovalid_q || out_ready_i) begin
          logic [2:0] st;
          st = pst_q;
          if (inw_q.mode) begin
            if (viol_q) st = acpu_pkg::StAccess;
            else if (bad_q) st = acpu_pkg::StBadOp;
            else if (stop_q) st = acpu_pkg::StHalt;
          end
          if (inw_q.mode && !halt_q) begin
            if (stop_q) begin
              halt_d = 1'b1;
            end else begin
              pc_d = {{(32-AW){1'b0}}, next_q[AW-1:0]};
              if (tick_inc >= period_ext) begin
                tick_d = 16'd0; tpend_d = 1'b1;
              end else begin
                tick_d = tick_inc[15:0];
              end
            end
          end
          odata_d.status = st;
          odata_d.print_value = (st == acpu_pkg::StInt || st == acpu_pkg::StChar)
                                ? ac_q : 32'd0;
          odata_d.program_counter = 11'(pc_d);
          odata_d.kernel_mode = kern_q;
          ovalid_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    // user touching system memory, after wrap
    if (acc && !kern_d && (maddr[AW-1:0] >= AW'(acpu_pkg::UserLimit))) begin
      viol_d = 1'b1;
    end
  end

  // control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; pc_q <= '0; sp_q <= 32'(acpu_pkg::SpReset);
      ac_q <= '0; x_q <= '0; y_q <= '0; kern_q <= 1'b0; tpend_q <= 1'b0;
      halt_q <= 1'b0; ikind_q <= acpu_pkg::IntNone; tick_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; pc_q <= pc_d; sp_q <= sp_d; ac_q <= ac_d;
      x_q <= x_d; y_q <= y_d; kern_q <= kern_d; tpend_q <= tpend_d;
      halt_q <= halt_d; ikind_q <= ikind_d; tick_q <= tick_d;
      ovalid_q <= ovalid_d;
    end
  end

  // per-step working registers
  always_ff @(posedge clk_i) begin
    next_q <= next_d; op_q <= op_d; tmp_q <= tmp_d; viol_q <= viol_d;
    bad_q <= bad_d; stop_q <= stop_d; pst_q <= pst_d; odata_q <= odata_d;
    inw_q <= inw_d;
  end

endmodule

// File: rtl/acpu_mem.sv
// ----------------------------------------------------------------------------
// acpu_mem
// Single-port word memory with registered read data.
// ----------------------------------------------------------------------------
module acpu_mem #(
  parameter int unsigned MemWords = acpu_pkg::MemWordsDefault,
  localparam int unsigned AW = $clog2(MemWords)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [31:0]   wdata_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [MemWords];

  // write or read one word a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: rtl/acpu_checker.sv
// ----------------------------------------------------------------------------
// acpu_checker
// Port-level checks on the accumulator processor, bound to the top level.
// ----------------------------------------------------------------------------
module acpu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input acpu_pkg::out_word_t out_data_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // print value is zero unless printing
  a_pv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != acpu_pkg::StInt
      && out_data_o.status != acpu_pkg::StChar |-> out_data_o.print_value == 32'd0)
    else $error("print value set without print status");

  // status code within range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= acpu_pkg::StAccess)
    else $error("bad status code");

  // no word taken the cycle after one is taken
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken back to back");

endmodule

bind accumulator_cpu_with_interrupts acpu_checker u_acpu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
